// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the vertex normal averaging RTL.
// Included by bare file name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset
`define VNA_ASSERT_IMP(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset
`define VNA_ASSERT_NXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== hdl/vna_pkg.sv =====
// Shared types and fixed widths of the vertex normal averaging block.
// No dependencies.
`default_nettype none

package vna_pkg;

   localparam int COORD_W     = 24;
   localparam int EDGE_W      = COORD_W + 1;
   localparam int NORMAL_FRAC = 14;
   localparam int NORM_W      = NORMAL_FRAC + 2;

   // One triangle, as offered on the input channel
   typedef struct packed {
      logic signed [COORD_W-1:0] p1_x;
      logic signed [COORD_W-1:0] p1_y;
      logic signed [COORD_W-1:0] p1_z;
      logic signed [COORD_W-1:0] p2_x;
      logic signed [COORD_W-1:0] p2_y;
      logic signed [COORD_W-1:0] p2_z;
      logic signed [COORD_W-1:0] p3_x;
      logic signed [COORD_W-1:0] p3_y;
      logic signed [COORD_W-1:0] p3_z;
      logic                      last_face;
   } vna_req_type;

   // Averaged vertex normal
   typedef struct packed {
      logic signed [NORM_W-1:0] normal_x;
      logic signed [NORM_W-1:0] normal_y;
      logic signed [NORM_W-1:0] normal_z;
   } vna_rsp_type;

   // Classified face, passed from the front end to the back end
   typedef struct packed {
      logic signed [EDGE_W-1:0] e1_x;
      logic signed [EDGE_W-1:0] e1_y;
      logic signed [EDGE_W-1:0] e1_z;
      logic signed [EDGE_W-1:0] e2_x;
      logic signed [EDGE_W-1:0] e2_y;
      logic signed [EDGE_W-1:0] e2_z;
      logic                     active;
      logic                     last;
   } vna_face_type;

endpackage

`default_nettype wire

// ===== hdl/vna_queue.sv =====
// Two-entry queue of classified faces between front and back end.
// Depends on vna_pkg.
`default_nettype none

module vna_queue import vna_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  vna_face_type push_data,
   output logic         full,
   input  logic         pop,
   output logic         pop_valid,
   output vna_face_type pop_data
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   vna_face_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         if (do_push && !do_pop) count_ff <= count_ff + CNT_W'(1);
         else if (do_pop && !do_push) count_ff <= count_ff - CNT_W'(1);
      end
   end

endmodule

`default_nettype wire

// ===== hdl/vna_front.sv =====
// Front end: takes triangles, forms edge vectors, marks faces past the limit.
// Depends on vna_pkg.
`default_nettype none

module vna_front import vna_pkg::*; #(
   parameter int MAX_FACES = 255
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  vna_req_type  req_data,
   output logic         push,
   output vna_face_type push_data,
   input  logic         full
);

   localparam int CNT_W = $clog2(MAX_FACES + 1);

   logic [CNT_W-1:0] cnt_ff;
   logic             active;

   assign req_stall = full;
   assign push      = req_valid && !full;
   assign active    = (cnt_ff < CNT_W'(MAX_FACES));

   // edges e1 = p1 - p2, e2 = p2 - p3
   always_comb begin
      push_data.e1_x   = EDGE_W'($signed(req_data.p1_x)) - EDGE_W'($signed(req_data.p2_x));
      push_data.e1_y   = EDGE_W'($signed(req_data.p1_y)) - EDGE_W'($signed(req_data.p2_y));
      push_data.e1_z   = EDGE_W'($signed(req_data.p1_z)) - EDGE_W'($signed(req_data.p2_z));
      push_data.e2_x   = EDGE_W'($signed(req_data.p2_x)) - EDGE_W'($signed(req_data.p3_x));
      push_data.e2_y   = EDGE_W'($signed(req_data.p2_y)) - EDGE_W'($signed(req_data.p3_y));
      push_data.e2_z   = EDGE_W'($signed(req_data.p2_z)) - EDGE_W'($signed(req_data.p3_z));
      push_data.active = active;
      push_data.last   = req_data.last_face;
   end

   // per-vertex face count, for the limit check only
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (push) begin
         if (req_data.last_face) cnt_ff <= '0;
         else if (active)        cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

endmodule

`default_nettype wire

// ===== hdl/vna_back.sv =====
// Back end: cross product, unit scaling by exact division and square root,
// running sums and the final average. Depends on vna_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module vna_back import vna_pkg::*; #(
   parameter int MAX_FACES   = 255
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         pop_valid,
   input  vna_face_type pop_data,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output vna_rsp_type  rsp_data
);

   localparam int EW   = EDGE_W;
   localparam int PW   = 2 * EW;             // signed cross product
   localparam int MW   = 2 * EW - 1;         // its magnitude
   localparam int SQW  = 2 * MW;             // one square
   localparam int LW   = SQW + 2;            // squared length
   localparam int RMW  = LW + 1;             // divider remainder
   localparam int DIGW = 16;                 // multiplier digit
   localparam int ND   = (MW + DIGW - 1) / DIGW;
   localparam int MPW  = ND * DIGW;
   localparam int DIW  = (ND > 1) ? $clog2(ND) : 1;
   localparam int QW   = 2 * NORMAL_FRAC + 1;
   localparam int RW   = NORMAL_FRAC + 1;
   localparam int CNW  = $clog2(MAX_FACES + 1);
   localparam int SMW  = NORMAL_FRAC + CNW + 1;
   localparam int SW   = SMW + 1;
   localparam int SMAX = (QW > SMW) ? QW : SMW;
   localparam int STW  = $clog2(SMAX + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_CROSS, ST_SQUARE, ST_CHECK, ST_LOAD,
      ST_DIV, ST_SQRT, ST_ADD, ST_COUNT, ST_AVG, ST_OUT
   } state_type;

   state_type               state_ff;
   vna_face_type            face_ff;
   logic signed [PW-1:0]    prod_ff;
   logic signed [PW-1:0]    cr_ff [3];
   logic [SQW-1:0]          sq_ff [3];
   logic [SQW-1:0]          acc_ff;
   logic [LW-1:0]           l2_ff;
   logic [RMW-1:0]          rem_ff;
   logic [QW-1:0]           quo_ff;
   logic [RW-1:0]           root_ff;
   logic signed [SW-1:0]    sum_ff [3];
   logic [CNW-1:0]          cnt_ff;
   logic [SMW-1:0]          dv_ff;
   logic [CNW-1:0]          dr_ff;
   logic signed [NORM_W-1:0] res_ff [3];
   logic [1:0]              ax_ff;
   logic [STW-1:0]          step_ff;
   logic                    rsp_valid_ff;
   vna_rsp_type             rsp_data_ff;

   logic signed [EW-1:0]    mul_a, mul_b;
   logic signed [PW-1:0]    mul_p;
   logic signed [PW-1:0]    cr_sel;
   logic [MW-1:0]           cr_mag;
   logic [MPW-1:0]          mpad;
   logic [DIW-1:0]          dig_idx;
   logic [DIGW-1:0]         dig;
   logic [MW+DIGW-1:0]      pp;
   logic [SQW-1:0]          acc_next;
   logic                    ge;
   logic [RMW-1:0]          rem_sub, rem_next;
   logic [QW-1:0]           quo_next;
   logic [RW-1:0]           cand;
   logic [2*RW-1:0]         cand_sq, root_sq;
   logic                    fits;
   logic signed [SW-1:0]    unit_val;
   logic [CNW:0]            dr2;
   logic                    ge2;
   logic [CNW-1:0]          dr_next;
   logic [SMW-1:0]          dv_next;
   logic signed [SW-1:0]    sum_sel, avg_q, avg_res;
   logic                    out_load;

   function automatic logic [SMW-1:0] sum_mag(input logic signed [SW-1:0] s);
      sum_mag = SMW'(s[SW-1] ? -s : s);
   endfunction

   assign pop       = (state_ff == ST_IDLE) && pop_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   // result register can take a new item
   assign out_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   // cross product operands: two products per axis
   always_comb begin
      unique case (step_ff[2:0])
         3'd0:    begin mul_a = face_ff.e1_y; mul_b = face_ff.e2_z; end
         3'd1:    begin mul_a = face_ff.e1_z; mul_b = face_ff.e2_y; end
         3'd2:    begin mul_a = face_ff.e1_z; mul_b = face_ff.e2_x; end
         3'd3:    begin mul_a = face_ff.e1_x; mul_b = face_ff.e2_z; end
         3'd4:    begin mul_a = face_ff.e1_x; mul_b = face_ff.e2_y; end
         3'd5:    begin mul_a = face_ff.e1_y; mul_b = face_ff.e2_x; end
         default: begin mul_a = '0;           mul_b = '0;           end
      endcase
      mul_p = PW'(mul_a) * PW'(mul_b);
   end

   // squaring, one 16-bit digit per cycle, top digit first
   always_comb begin
      cr_sel   = cr_ff[ax_ff];
      cr_mag   = MW'(cr_sel[PW-1] ? -cr_sel : cr_sel);
      mpad     = MPW'(cr_mag);
      dig_idx  = step_ff[DIW-1:0];
      dig      = mpad[DIGW*dig_idx +: DIGW];
      pp       = cr_mag * dig;
      acc_next = (acc_ff << DIGW) + SQW'(pp);
   end

   // restoring division c^2 * 4^F / L2, one quotient bit per cycle
   always_comb begin
      ge       = (rem_ff >= RMW'(l2_ff));
      rem_sub  = ge ? rem_ff - RMW'(l2_ff) : rem_ff;
      rem_next = rem_sub << 1;
      quo_next = {quo_ff[QW-2:0], ge};
   end

   // integer square root of the quotient, one root bit per cycle
   always_comb begin
      cand     = root_ff | (RW'(1) << step_ff);
      cand_sq  = cand * cand;
      root_sq  = root_ff * root_ff;
      fits     = (cand_sq <= (2*RW)'(quo_ff));
      unit_val = cr_sel[PW-1] ? -SW'(root_ff) : SW'(root_ff);
   end

   // average: sum magnitude divided by face count, bit serial
   always_comb begin
      dr2     = {dr_ff, dv_ff[SMW-1]};
      ge2     = (dr2 >= {1'b0, cnt_ff});
      dr_next = CNW'(ge2 ? dr2 - {1'b0, cnt_ff} : dr2);
      dv_next = {dv_ff[SMW-2:0], ge2};
      sum_sel = sum_ff[ax_ff];
      avg_q   = SW'(dv_next);
      avg_res = sum_sel[SW-1] ? -avg_q : avg_q;
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         sum_ff[0]    <= '0;
         sum_ff[1]    <= '0;
         sum_ff[2]    <= '0;
      end else begin
         rsp_valid_ff <= out_load || (rsp_valid_ff && rsp_stall);
         unique case (state_ff)
            ST_IDLE: begin
               if (pop_valid) begin
                  face_ff <= pop_data;
                  l2_ff   <= '0;
                  acc_ff  <= '0;
                  if (pop_data.active) begin
                     step_ff  <= '0;
                     state_ff <= ST_CROSS;
                  end else if (pop_data.last) begin
                     ax_ff    <= 2'd0;
                     dv_ff    <= sum_mag(sum_ff[0]);
                     dr_ff    <= '0;
                     step_ff  <= STW'(SMW - 1);
                     state_ff <= ST_AVG;
                  end
               end
            end
            ST_CROSS: begin
               if (!step_ff[0]) prod_ff <= mul_p;
               else             cr_ff[step_ff[2:1]] <= prod_ff - mul_p;
               if (step_ff == STW'(5)) begin
                  ax_ff    <= 2'd0;
                  step_ff  <= STW'(ND - 1);
                  state_ff <= ST_SQUARE;
               end else begin
                  step_ff <= step_ff + STW'(1);
               end
            end
            ST_SQUARE: begin
               if (step_ff == '0) begin
                  sq_ff[ax_ff] <= acc_next;
                  l2_ff        <= l2_ff + LW'(acc_next);
                  acc_ff       <= '0;
                  step_ff      <= STW'(ND - 1);
                  if (ax_ff == 2'd2) state_ff <= ST_CHECK;
                  else               ax_ff    <= ax_ff + 2'd1;
               end else begin
                  acc_ff  <= acc_next;
                  step_ff <= step_ff - STW'(1);
               end
            end
            ST_CHECK: begin
               // degenerate triangle adds nothing but is still counted
               ax_ff    <= 2'd0;
               state_ff <= (l2_ff == '0) ? ST_COUNT : ST_LOAD;
            end
            ST_LOAD: begin
               rem_ff   <= RMW'(sq_ff[ax_ff]);
               quo_ff   <= '0;
               step_ff  <= STW'(QW - 1);
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               rem_ff <= rem_next;
               quo_ff <= quo_next;
               if (step_ff == '0) begin
                  root_ff  <= '0;
                  step_ff  <= STW'(NORMAL_FRAC);
                  state_ff <= ST_SQRT;
               end else begin
                  step_ff <= step_ff - STW'(1);
               end
            end
            ST_SQRT: begin
               if (fits) root_ff <= cand;
               if (step_ff == '0) state_ff <= ST_ADD;
               else               step_ff  <= step_ff - STW'(1);
            end
            ST_ADD: begin
               sum_ff[ax_ff] <= sum_sel + unit_val;
               if (ax_ff == 2'd2) begin
                  state_ff <= ST_COUNT;
               end else begin
                  ax_ff    <= ax_ff + 2'd1;
                  state_ff <= ST_LOAD;
               end
            end
            ST_COUNT: begin
               cnt_ff <= cnt_ff + CNW'(1);
               if (face_ff.last) begin
                  ax_ff    <= 2'd0;
                  dv_ff    <= sum_mag(sum_ff[0]);
                  dr_ff    <= '0;
                  step_ff  <= STW'(SMW - 1);
                  state_ff <= ST_AVG;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_AVG: begin
               if (step_ff == '0) begin
                  res_ff[ax_ff] <= NORM_W'(avg_res);
                  if (ax_ff == 2'd2) begin
                     state_ff <= ST_OUT;
                  end else begin
                     ax_ff   <= ax_ff + 2'd1;
                     dv_ff   <= sum_mag(sum_ff[ax_ff + 2'd1]);
                     dr_ff   <= '0;
                     step_ff <= STW'(SMW - 1);
                  end
               end else begin
                  dv_ff   <= dv_next;
                  dr_ff   <= dr_next;
                  step_ff <= step_ff - STW'(1);
               end
            end
            ST_OUT: begin
               if (out_load) begin
                  rsp_data_ff.normal_x <= res_ff[0];
                  rsp_data_ff.normal_y <= res_ff[1];
                  rsp_data_ff.normal_z <= res_ff[2];
                  sum_ff[0]            <= '0;
                  sum_ff[1]            <= '0;
                  sum_ff[2]            <= '0;
                  cnt_ff               <= '0;
                  state_ff             <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `VNA_ASSERT_IMP(a_div_rem_bound, clock, reset, state_ff == ST_DIV, rem_ff < (RMW'(l2_ff) << 1), "divider remainder out of range")
   `VNA_ASSERT_IMP(a_root_below, clock, reset, state_ff == ST_SQRT, root_sq <= (2*RW)'(quo_ff), "partial root too large")
   `VNA_ASSERT_NXT(a_out_clears, clock, reset, out_load, rsp_valid_ff && (cnt_ff == '0), "result load did not clear the vertex")

endmodule

`default_nettype wire

// ===== hdl/vertex_normal_average_core.sv =====
// Vertex normal averaging, top level.
// Input channel req_*: one triangle per item (three signed Q15.8 points and
// a last_face flag). Result channel rsp_*: one averaged unit normal, signed
// Q1.14, after each item flagged last_face; other items give no result.
// Both channels move an item when valid is high and stall is low.
// The front end forms the edge vectors and queues faces (two entries); the
// back end works one face at a time with a shared cross-product multiplier,
// a digit-serial squaring multiplier, a bit-serial divider and a bit-serial
// square root. The squaring multiplier works on ND = 4 digits per square.
// A last face adds the average step over the running sums.
// Reset (synchronous, active high) empties the queue and clears the sums and
// face counts. A stalled result waits in the output register; the back end
// keeps working on the next faces and only waits when a further result is due.
`default_nettype none

module vertex_normal_average_core import vna_pkg::*; #(
   parameter int MAX_FACES   = 255
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  vna_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output vna_rsp_type rsp_data
);

   logic         push, full, pop, pop_valid;
   vna_face_type push_data, pop_data;

   vna_front #(
      .MAX_FACES (MAX_FACES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .push      (push),
      .push_data (push_data),
      .full      (full)
   );

   vna_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_data  (pop_data)
   );

   vna_back #(
      .MAX_FACES   (MAX_FACES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
